@@ hw/rtl/bls_pkg.sv @@
// Package for the band-limited step synthesiser: field widths, item kinds,
// reset values, controller/datapath command and status structs, saturating add.
// No dependencies.
package bls_pkg;

   localparam int TAPS_DEFAULT             = 32;
   localparam int OVERSAMPLE_DEFAULT       = 16;
   localparam int SAMPLES_PER_TICK_DEFAULT = 48;
   localparam int RING_DEPTH_DEFAULT       = 128;

   localparam int STEP_TIME_W   = 17;
   localparam int LEVEL_W       = 16;
   localparam int COEFF_INDEX_W = 9;
   localparam int COEFF_W       = 16;
   localparam int SAMPLE_W      = 32;
   localparam int QUIET_W       = 16;
   localparam int FADE_W        = 16;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_STEP = 2'd1;
   localparam logic [1:0] KIND_EMIT = 2'd2;

   localparam logic [STEP_TIME_W-1:0] FULL_TICK  = 17'd65536;
   localparam logic [FADE_W-1:0]      FADE_RESET = 16'd65400;
   localparam logic [QUIET_W-1:0]     QUIET_MAX  = 16'hFFFF;
   localparam logic signed [SAMPLE_W-1:0] ONE_UNIT     = 32'sd32768;
   localparam logic signed [SAMPLE_W-1:0] NEG_ONE_UNIT = -32'sd32768;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_coeff;
      logic capture_step;
      logic step_mul;
      logic step_setup;
      logic tap_issue;
      logic head_pop;
      logic sum_update;
      logic out_load;
      logic fade_apply;
   } bls_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic level_same;
      logic taps_left;
      logic pipe_busy;
      logic out_free;
   } bls_status_type;

   // Signed 32-bit add that clips at both ends of the range.
   function automatic logic signed [SAMPLE_W-1:0] sat_add32(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b
   );
      logic signed [SAMPLE_W:0] s;
      logic signed [SAMPLE_W-1:0] r;
      s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
      if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
         r = s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         r = s[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/bls_ctrl.sv @@
// Controller state machine of the band-limited step synthesiser.
// Sequences coefficient loads, step spreading and sample emission; uses bls_pkg.
module bls_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_kind,
   input  bls_pkg::bls_status_type status,
   output bls_pkg::bls_cmd_type    cmd
);
   import bls_pkg::*;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_STEP_MUL   = 4'd1;
   localparam logic [3:0] S_STEP_SETUP = 4'd2;
   localparam logic [3:0] S_STEP_RUN   = 4'd3;
   localparam logic [3:0] S_STEP_DRAIN = 4'd4;
   localparam logic [3:0] S_EMIT_POP   = 4'd5;
   localparam logic [3:0] S_EMIT_SUM   = 4'd6;
   localparam logic [3:0] S_EMIT_OUT   = 4'd7;
   localparam logic [3:0] S_EMIT_FADE  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_LOAD: begin
                     cmd.load_coeff = 1'b1;
                  end
                  KIND_STEP: begin
                     if (!status.level_same) begin
                        cmd.capture_step = 1'b1;
                        state_in         = S_STEP_MUL;
                     end
                  end
                  KIND_EMIT: begin
                     state_in = S_EMIT_POP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_STEP_MUL: begin
            cmd.step_mul = 1'b1;
            state_in     = S_STEP_SETUP;
         end
         S_STEP_SETUP: begin
            cmd.step_setup = 1'b1;
            state_in       = S_STEP_RUN;
         end
         S_STEP_RUN: begin
            if (status.taps_left) begin
               cmd.tap_issue = 1'b1;
            end else begin
               state_in = S_STEP_DRAIN;
            end
         end
         S_STEP_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_IDLE;
            end
         end
         S_EMIT_POP: begin
            cmd.head_pop = 1'b1;
            state_in     = S_EMIT_SUM;
         end
         S_EMIT_SUM: begin
            cmd.sum_update = 1'b1;
            state_in       = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_EMIT_FADE;
            end
         end
         S_EMIT_FADE: begin
            cmd.fade_apply = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/bls_datapath.sv @@
// Datapath of the band-limited step synthesiser: coefficient table, delta ring,
// step timing, tap multiply-accumulate pipeline, running sum and output register.
// Uses bls_pkg; driven by bls_ctrl.
module bls_datapath #(
   parameter int TAPS             = bls_pkg::TAPS_DEFAULT,
   parameter int OVERSAMPLE       = bls_pkg::OVERSAMPLE_DEFAULT,
   parameter int SAMPLES_PER_TICK = bls_pkg::SAMPLES_PER_TICK_DEFAULT,
   parameter int RING_DEPTH       = bls_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [bls_pkg::STEP_TIME_W-1:0]            req_step_time,
   input  logic signed [bls_pkg::LEVEL_W-1:0]         req_level,
   input  logic [bls_pkg::COEFF_INDEX_W-1:0]          req_coeff_index,
   input  logic signed [bls_pkg::COEFF_W-1:0]         req_coeff_value,
   input  logic                                       csr_wr_en,
   input  logic [bls_pkg::FADE_W-1:0]                 csr_wr_data,
   input  bls_pkg::bls_cmd_type                       cmd,
   output bls_pkg::bls_status_type                    status,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [bls_pkg::SAMPLE_W-1:0]        rsp_sample,
   output logic [bls_pkg::QUIET_W-1:0]                rsp_quiet_count
);
   import bls_pkg::*;

   localparam int TABLE_DEPTH = TAPS * OVERSAMPLE;
   localparam int TA_W    = $clog2(TABLE_DEPTH);
   localparam int TD_W    = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W   = (TD_W > COEFF_INDEX_W) ? TD_W : COEFF_INDEX_W;
   localparam int RA_W    = $clog2(RING_DEPTH);
   localparam int POS_MUL = SAMPLES_PER_TICK * OVERSAMPLE;
   localparam int POS_W   = $clog2(POS_MUL + 1);
   localparam int PPROD_W = STEP_TIME_W + POS_W;
   localparam int Q_W     = $clog2(SAMPLES_PER_TICK + 1);
   localparam int QPROD_W = STEP_TIME_W + Q_W;
   localparam int R_W     = $clog2(OVERSAMPLE);
   localparam int K_W     = $clog2(TAPS + 1);
   localparam int CW      = $clog2(RING_DEPTH + SAMPLES_PER_TICK + TAPS + 2) + 1;
   localparam int FPROD_W = SAMPLE_W + FADE_W + 1;

   // Storage.
   logic signed [COEFF_W-1:0]  coeff_mem [TABLE_DEPTH];
   logic signed [SAMPLE_W-1:0] ring_mem  [RING_DEPTH];
   logic [RING_DEPTH-1:0]      ring_valid_ff;

   // Control and state registers.
   logic [FADE_W-1:0]            fade_ff;
   logic signed [LEVEL_W-1:0]    last_level_ff;
   logic [RA_W-1:0]              head_ff;
   logic signed [SAMPLE_W-1:0]   running_sum_ff;
   logic [QUIET_W-1:0]           quiet_run_ff;
   logic                         rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]   rsp_sample_ff;
   logic [QUIET_W-1:0]           rsp_quiet_ff;
   logic                         s1_valid_ff;
   logic                         s2_valid_ff;

   // Step registers.
   logic [STEP_TIME_W-1:0]       t_ff;
   logic signed [LEVEL_W-1:0]    level_ff;
   logic [POS_W-1:0]             pos_ff;
   logic [Q_W-1:0]               q_ff;
   logic [K_W-1:0]               k_ff;
   logic [K_W-1:0]               k_last_ff;
   logic [TA_W-1:0]              taddr_ff;
   logic [RA_W-1:0]              raddr_ff;

   // Tap pipeline registers.
   logic signed [COEFF_W-1:0]    coeff_q_ff;
   logic signed [SAMPLE_W-1:0]   ring_q_ff;
   logic                         ring_v_ff;
   logic [RA_W-1:0]              s1_addr_ff;
   logic [RA_W-1:0]              s2_addr_ff;
   logic signed [SAMPLE_W-1:0]   tap_prod_ff;
   logic signed [SAMPLE_W-1:0]   delta2_ff;
   logic signed [FPROD_W-1:0]    fade_prod_ff;

   // Combinational signals.
   logic [IDX_W-1:0]             idx_ext;
   logic                         idx_ok;
   logic [PPROD_W-1:0]           pos_prod;
   logic [QPROD_W-1:0]           q_prod;
   logic [POS_W-1:0]             r_full;
   logic [R_W-1:0]               r;
   logic                         r_nz;
   logic [R_W:0]                 phase_full;
   logic [R_W-1:0]               phase;
   logic [CW-1:0]                off_c;
   logic [CW-1:0]                room;
   logic [K_W-1:0]               k_last_in;
   logic [CW-1:0]                rstart;
   logic [RA_W-1:0]              raddr_in;
   logic [TA_W-1:0]              taddr_in;
   logic [RA_W-1:0]              rd_addr;
   logic signed [SAMPLE_W-1:0]   popped;
   logic [QUIET_W-1:0]           quiet_in;
   logic signed [FPROD_W-1:0]    fade_biased;
   logic signed [SAMPLE_W-1:0]   faded;
   logic [STEP_TIME_W-1:0]       t_in;

   assign idx_ext = IDX_W'(req_coeff_index);
   assign idx_ok  = (idx_ext < IDX_W'(TABLE_DEPTH));
   assign t_in    = (req_step_time > FULL_TICK) ? FULL_TICK : req_step_time;

   // Position in oversampled units, and the whole-sample part found directly.
   assign pos_prod = PPROD_W'(t_ff) * PPROD_W'(POS_MUL);
   assign q_prod   = QPROD_W'(t_ff) * QPROD_W'(SAMPLES_PER_TICK);

   always_comb begin
      r_full     = pos_ff - POS_W'(POS_W'(q_ff) * POS_W'(OVERSAMPLE));
      r          = r_full[R_W-1:0];
      r_nz       = (r != '0);
      phase_full = (R_W+1)'(OVERSAMPLE) - (R_W+1)'(r);
      phase      = r_nz ? phase_full[R_W-1:0] : '0;
      off_c      = CW'(q_ff) + CW'(r_nz);
      room       = CW'(RING_DEPTH) - off_c;
      if (off_c >= CW'(RING_DEPTH)) begin
         k_last_in = '0;
      end else if (room > CW'(TAPS)) begin
         k_last_in = K_W'(TAPS);
      end else begin
         k_last_in = room[K_W-1:0];
      end
      rstart = CW'(head_ff) + off_c + CW'(!r_nz);
      if (rstart >= CW'(RING_DEPTH)) begin
         rstart = rstart - CW'(RING_DEPTH);
      end
      raddr_in = rstart[RA_W-1:0];
      taddr_in = TA_W'(phase) + (r_nz ? TA_W'(0) : TA_W'(OVERSAMPLE));
   end

   assign rd_addr = cmd.head_pop ? head_ff : raddr_ff;
   assign popped  = ring_v_ff ? ring_q_ff : '0;

   always_comb begin
      if (running_sum_ff > ONE_UNIT || running_sum_ff < NEG_ONE_UNIT) begin
         quiet_in = '0;
      end else if (quiet_run_ff == QUIET_MAX) begin
         quiet_in = quiet_run_ff;
      end else begin
         quiet_in = quiet_run_ff + QUIET_W'(1);
      end
   end

   // Fade result truncated toward zero.
   assign fade_biased = fade_prod_ff +
      (fade_prod_ff[FPROD_W-1] ? FPROD_W'(65535) : FPROD_W'(0));
   assign faded = fade_biased[FADE_W +: SAMPLE_W];

   always_comb begin
      status.level_same = (req_level == last_level_ff);
      status.taps_left  = (k_ff < k_last_ff);
      status.pipe_busy  = s1_valid_ff || s2_valid_ff;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_quiet_count = rsp_quiet_ff;

   // Coefficient table.
   always_ff @(posedge clock) begin
      if (cmd.load_coeff && idx_ok) begin
         coeff_mem[idx_ext[TA_W-1:0]] <= req_coeff_value;
      end
      if (cmd.tap_issue) begin
         coeff_q_ff <= coeff_mem[taddr_ff];
      end
   end

   // Delta ring.
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         ring_mem[s2_addr_ff] <= sat_add32(delta2_ff, tap_prod_ff);
      end
      if (cmd.tap_issue || cmd.head_pop) begin
         ring_q_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         ring_v_ff     <= 1'b0;
      end else begin
         if (cmd.tap_issue || cmd.head_pop) begin
            ring_v_ff <= ring_valid_ff[rd_addr];
         end
         if (s2_valid_ff) begin
            ring_valid_ff[s2_addr_ff] <= 1'b1;
         end
         if (cmd.head_pop) begin
            ring_valid_ff[head_ff] <= 1'b0;
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ff        <= FADE_RESET;
         last_level_ff  <= '0;
         head_ff        <= '0;
         running_sum_ff <= '0;
         quiet_run_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         k_ff           <= '0;
         k_last_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            fade_ff <= csr_wr_data;
         end
         if (cmd.capture_step) begin
            last_level_ff <= req_level;
         end
         if (cmd.head_pop) begin
            head_ff <= (head_ff == RA_W'(RING_DEPTH - 1)) ? '0 : head_ff + RA_W'(1);
         end
         if (cmd.sum_update) begin
            running_sum_ff <= sat_add32(running_sum_ff, popped);
         end else if (cmd.fade_apply) begin
            running_sum_ff <= faded;
         end
         if (cmd.out_load) begin
            quiet_run_ff <= quiet_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         s1_valid_ff <= cmd.tap_issue;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.step_setup) begin
            k_ff      <= K_W'(!r_nz);
            k_last_ff <= k_last_in;
         end else if (cmd.tap_issue) begin
            k_ff <= k_ff + K_W'(1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture_step) begin
         t_ff     <= t_in;
         level_ff <= req_level;
      end
      if (cmd.step_mul) begin
         pos_ff <= pos_prod[16 +: POS_W];
         q_ff   <= q_prod[16 +: Q_W];
      end
      if (cmd.step_setup) begin
         taddr_ff <= taddr_in;
         raddr_ff <= raddr_in;
      end else if (cmd.tap_issue) begin
         taddr_ff <= taddr_ff + TA_W'(OVERSAMPLE);
         raddr_ff <= (raddr_ff == RA_W'(RING_DEPTH - 1)) ? '0 : raddr_ff + RA_W'(1);
      end
      s1_addr_ff  <= raddr_ff;
      s2_addr_ff  <= s1_addr_ff;
      tap_prod_ff <= SAMPLE_W'(level_ff) * SAMPLE_W'(coeff_q_ff);
      delta2_ff   <= ring_v_ff ? ring_q_ff : '0;
      if (cmd.out_load) begin
         rsp_sample_ff <= running_sum_ff;
         rsp_quiet_ff  <= quiet_in;
         fade_prod_ff  <= FPROD_W'(running_sum_ff) * $signed({1'b0, fade_ff});
      end
   end

endmodule

@@ hw/rtl/bandlimited_step_synth.sv @@
// Top level of the band-limited step synthesiser.
// Instantiates bls_ctrl and bls_datapath; uses bls_pkg.
//
//   Port group  Direction  Handshake          Carries
//   req_*       in         req_valid/stall    kind, step_time, level, coeff_index, coeff_value
//   rsp_*       out        rsp_valid/stall    sample, quiet_count (one per emit item)
//   csr_*       in         csr_wr_en          fade_factor, written with no wait
//
// A coefficient load, like a step whose level matches the last one, leaves the controller idle.
// A step that changes the level runs the multiply and setup states, then one ring entry per
// cycle is read, multiplied and written back through a three-deep pipe, which then drains.
// An emit pops the head, updates the sum, loads the output once rsp_stall frees it, then fades.
// After reset the ring reads as zero at once through per-entry valid bits; no clearing pass.
// The coefficient table holds no defined contents until loaded.
module bandlimited_step_synth #(
   parameter int TAPS             = bls_pkg::TAPS_DEFAULT,
   parameter int OVERSAMPLE       = bls_pkg::OVERSAMPLE_DEFAULT,
   parameter int SAMPLES_PER_TICK = bls_pkg::SAMPLES_PER_TICK_DEFAULT,
   parameter int RING_DEPTH       = bls_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_kind,
   input  logic [bls_pkg::STEP_TIME_W-1:0]      req_step_time,
   input  logic signed [bls_pkg::LEVEL_W-1:0]   req_level,
   input  logic [bls_pkg::COEFF_INDEX_W-1:0]    req_coeff_index,
   input  logic signed [bls_pkg::COEFF_W-1:0]   req_coeff_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bls_pkg::SAMPLE_W-1:0]  rsp_sample,
   output logic [bls_pkg::QUIET_W-1:0]          rsp_quiet_count,
   input  logic                                 csr_wr_en,
   input  logic [bls_pkg::FADE_W-1:0]           csr_wr_data
);
   import bls_pkg::*;

   // The controller only takes a transfer while idle; the datapath tells it whether a
   // step repeats the last level, whether taps remain, whether the pipe has drained and whether the output is free.
   bls_cmd_type    cmd;
   bls_status_type status;

   bls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd)
   );

   // The output register parts the result channel from the work: a finished sample
   // waits there while the next load or step is already being taken.
   bls_datapath #(
      .TAPS             (TAPS),
      .OVERSAMPLE       (OVERSAMPLE),
      .SAMPLES_PER_TICK (SAMPLES_PER_TICK),
      .RING_DEPTH       (RING_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_step_time   (req_step_time),
      .req_level       (req_level),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_quiet_count (rsp_quiet_count)
   );

endmodule
